/* src/rpnsc_pkg.sv */
package rpnsc_pkg;

  localparam int WORD_W          = 64;
  localparam int STACK_DEPTH_DEF = 128;
  localparam int VAR_COUNT_DEF   = 26;
  localparam int FRAC_BITS_DEF   = 32;

  localparam logic [3:0] MODE_PUSH    = 4'd0;
  localparam logic [3:0] MODE_ADD     = 4'd1;
  localparam logic [3:0] MODE_SUB     = 4'd2;
  localparam logic [3:0] MODE_MUL     = 4'd3;
  localparam logic [3:0] MODE_DIV     = 4'd4;
  localparam logic [3:0] MODE_MOD     = 4'd5;
  localparam logic [3:0] MODE_PEEK    = 4'd6;
  localparam logic [3:0] MODE_DUP     = 4'd7;
  localparam logic [3:0] MODE_SWAP    = 4'd8;
  localparam logic [3:0] MODE_CLEAR   = 4'd9;
  localparam logic [3:0] MODE_SETVAR  = 4'd10;
  localparam logic [3:0] MODE_GETVAR  = 4'd11;
  localparam logic [3:0] MODE_POPSHOW = 4'd12;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_EMPTY   = 3'd1;
  localparam logic [2:0] ERR_FULL    = 3'd2;
  localparam logic [2:0] ERR_ZERODIV = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN = 3'd4;
  localparam logic [2:0] ERR_SWAP    = 3'd5;

  localparam logic [1:0] UOP_MUL = 2'd0;
  localparam logic [1:0] UOP_DIV = 2'd1;
  localparam logic [1:0] UOP_MOD = 2'd2;

  localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [63:0] operand_value;
    logic [4:0]         var_index;
  } cmd_t;

  typedef struct packed {
    logic               shown;
    logic signed [63:0] shown_value;
    logic [2:0]         error_code;
    logic [7:0]         stack_depth;
  } res_t;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } unit_req_t;

  function automatic logic [63:0] magnitude(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // Apply a sign to an unsigned magnitude, clamping to the signed range.
  function automatic logic [63:0] sat_sign(input logic [63:0] mag, input logic neg,
                                           input logic ovf);
    logic [63:0] r;
    if (neg) begin
      r = (ovf || mag > MIN_NEG) ? MIN_NEG : (~mag + 64'd1);
    end else begin
      r = (ovf || mag[63]) ? MAX_POS : mag;
    end
    return r;
  endfunction

endpackage

/* src/rpn_stack_calculator_engine_unit.sv */
// RPN calculator on a stack of signed fixed-point words (FRACTION_BITS fraction bits).
// One request is taken at a time; cmd_ready is high only while the engine is idle.
// Every request first reads the top two stack entries through the single RAM read
// port, then executes: push, add, sub, peek, dup, clear, setvar, getvar, popshow
// and unknown commands go from the execute state straight to the output state,
// swap passes through one more state for its second write. Multiply and modulus
// run 64 steps of the shared shift/add-subtract unit, divide 64 + FRACTION_BITS
// steps (Q32.32 by default). A finished result sits in the output register, so the
// next request can be taken while it waits for res_ready.
module rpn_stack_calculator_engine_unit
  import rpnsc_pkg::*;
#(
  parameter int STACK_DEPTH    = STACK_DEPTH_DEF,
  parameter int VARIABLE_COUNT = VAR_COUNT_DEF,
  parameter int FRACTION_BITS  = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int VW  = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
  localparam logic [SPW-1:0] SP_ONE  = SPW'(1);
  localparam logic [SPW-1:0] SP_TWO  = SPW'(2);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_RD3  = 3'd3;
  localparam logic [2:0] S_EXEC = 3'd4;
  localparam logic [2:0] S_BUSY = 3'd5;
  localparam logic [2:0] S_SWAP = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]     state;
  logic [SPW-1:0] sp;
  cmd_t           cur;
  logic [63:0]    top;
  logic [63:0]    sec;
  logic           shown;
  logic [63:0]    shown_value;
  logic [2:0]     err;
  logic [63:0]    vars [VARIABLE_COUNT];

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [63:0]    ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [63:0]    ram_rdata;

  unit_req_t      ureq;
  logic           u_done;
  logic [63:0]    u_result;

  logic           has1, has2, full;
  logic [SPW-1:0] sp_m1, sp_m2, sp_pop1, sp_pop2;
  logic [63:0]    b_val, a_val;
  logic [64:0]    add_s, sub_s;
  logic [63:0]    add_sat, sub_sat;
  logic [6:0]     idx_ext;
  logic           idx_ok;
  logic [63:0]    var_rd;

  logic           ex_we;
  logic [SPW-1:0] ex_waddr;
  logic [63:0]    ex_wdata;
  logic [SPW-1:0] ex_sp;
  logic [2:0]     ex_err;
  logic           ex_shown;
  logic [63:0]    ex_val;
  logic           ex_start;
  logic           ex_var_we;
  logic [2:0]     ex_next;

  assign cmd_ready = (state == S_IDLE);

  assign has1    = (sp != '0);
  assign has2    = (sp > SP_ONE);
  assign full    = (sp >= SP_FULL);
  assign sp_m1   = sp - SP_ONE;
  assign sp_m2   = sp - SP_TWO;
  assign sp_pop1 = has1 ? sp_m1 : '0;
  assign sp_pop2 = has2 ? sp_m2 : '0;
  assign b_val   = has1 ? top : 64'd0;
  assign a_val   = has2 ? sec : 64'd0;

  assign add_s   = {a_val[63], a_val} + {b_val[63], b_val};
  assign sub_s   = {a_val[63], a_val} - {b_val[63], b_val};
  assign add_sat = (add_s[64] != add_s[63]) ? (add_s[64] ? MIN_NEG : MAX_POS) : add_s[63:0];
  assign sub_sat = (sub_s[64] != sub_s[63]) ? (sub_s[64] ? MIN_NEG : MAX_POS) : sub_s[63:0];

  assign idx_ext = {2'b00, cur.var_index};
  assign idx_ok  = (idx_ext < 7'(VARIABLE_COUNT));
  assign var_rd  = idx_ok ? vars[idx_ext[VW-1:0]] : 64'd0;

  assign ram_raddr = (state == S_RD1) ? sp_m1[AW-1:0] : sp_m2[AW-1:0];

  always_comb begin
    ex_we     = 1'b0;
    ex_waddr  = sp;
    ex_wdata  = 64'd0;
    ex_sp     = sp;
    ex_err    = ERR_NONE;
    ex_shown  = 1'b0;
    ex_val    = 64'd0;
    ex_start  = 1'b0;
    ex_var_we = 1'b0;
    ex_next   = S_OUT;
    unique case (cur.mode)
      MODE_PUSH, MODE_GETVAR: begin
        if (!full) begin
          ex_we    = 1'b1;
          ex_wdata = (cur.mode == MODE_PUSH) ? cur.operand_value : var_rd;
          ex_sp    = sp + SP_ONE;
        end else begin
          ex_err = ERR_FULL;
        end
      end
      MODE_ADD, MODE_SUB: begin
        ex_err   = has2 ? ERR_NONE : ERR_EMPTY;
        ex_we    = 1'b1;
        ex_waddr = sp_pop2;
        ex_wdata = (cur.mode == MODE_ADD) ? add_sat : sub_sat;
        ex_sp    = sp_pop2 + SP_ONE;
      end
      MODE_MUL: begin
        ex_err   = has2 ? ERR_NONE : ERR_EMPTY;
        ex_start = 1'b1;
        ex_next  = S_BUSY;
      end
      MODE_DIV, MODE_MOD: begin
        // A divisor of zero (modulus: integer part zero) is dropped, a stays put.
        if ((cur.mode == MODE_DIV && b_val == 64'd0) ||
            (cur.mode == MODE_MOD && (magnitude(b_val) >> FRACTION_BITS) == 64'd0)) begin
          ex_err = has1 ? ERR_ZERODIV : ERR_EMPTY;
          ex_sp  = sp_pop1;
        end else begin
          ex_err   = has2 ? ERR_NONE : ERR_EMPTY;
          ex_start = 1'b1;
          ex_next  = S_BUSY;
        end
      end
      MODE_PEEK: begin
        if (has1) begin
          ex_shown = 1'b1;
          ex_val   = top;
        end else begin
          ex_err = ERR_EMPTY;
        end
      end
      MODE_DUP: begin
        if (!has1) begin
          ex_err = ERR_EMPTY;
        end else if (full) begin
          ex_err = ERR_FULL;
        end else begin
          ex_we    = 1'b1;
          ex_wdata = top;
          ex_sp    = sp + SP_ONE;
        end
      end
      MODE_SWAP: begin
        if (has2) begin
          ex_we    = 1'b1;
          ex_waddr = sp_m1;
          ex_wdata = sec;
          ex_next  = S_SWAP;
        end else begin
          ex_err = ERR_SWAP;
        end
      end
      MODE_CLEAR: begin
        ex_sp = '0;
      end
      MODE_SETVAR: begin
        ex_err    = has1 ? ERR_NONE : ERR_EMPTY;
        ex_sp     = sp_pop1;
        ex_var_we = idx_ok;
      end
      MODE_POPSHOW: begin
        ex_err   = has1 ? ERR_NONE : ERR_EMPTY;
        ex_shown = 1'b1;
        ex_val   = b_val;
        ex_sp    = sp_pop1;
      end
      default: begin
        ex_err = ERR_UNKNOWN;
      end
    endcase
  end

  assign ureq.start = (state == S_EXEC) && ex_start;
  assign ureq.op    = (cur.mode == MODE_MUL) ? UOP_MUL :
                      (cur.mode == MODE_DIV) ? UOP_DIV : UOP_MOD;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sp[AW-1:0];
    ram_wdata = ex_wdata;
    unique case (state)
      S_EXEC: begin
        ram_we    = ex_we;
        ram_waddr = ex_waddr[AW-1:0];
        ram_wdata = ex_wdata;
      end
      S_BUSY: begin
        ram_we    = u_done;
        ram_waddr = sp_pop2[AW-1:0];
        ram_wdata = u_result;
      end
      S_SWAP: begin
        ram_we    = 1'b1;
        ram_waddr = sp_m2[AW-1:0];
        ram_wdata = top;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  rpnsc_stack_ram #(
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  rpnsc_iter_unit #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_unit (
    .clk   (clk),
    .rst   (rst),
    .req   (ureq),
    .a     (a_val),
    .b     (b_val),
    .done  (u_done),
    .result(u_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < VARIABLE_COUNT; i++) begin
        vars[i] <= 64'd0;
      end
    end else begin
      // The output state reloads the result register itself.
      if (res_valid && res_ready && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            state <= S_RD1;
          end
        end
        S_RD1: state <= S_RD2;
        S_RD2: begin
          top   <= ram_rdata;
          state <= S_RD3;
        end
        S_RD3: begin
          sec   <= ram_rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          sp          <= ex_sp;
          err         <= ex_err;
          shown       <= ex_shown;
          shown_value <= ex_val;
          if (ex_var_we) begin
            vars[idx_ext[VW-1:0]] <= b_val;
          end
          state <= ex_next;
        end
        S_BUSY: begin
          if (u_done) begin
            sp    <= sp_pop2 + SP_ONE;
            state <= S_OUT;
          end
        end
        S_SWAP: state <= S_OUT;
        default: begin
          if (!res_valid || res_ready) begin
            res.shown       <= shown;
            res.shown_value <= shown_value;
            res.error_code  <= err;
            res.stack_depth <= 8'(sp);
            res_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> (state == S_RD1))
    else $error("request accepted but engine did not start");

  a_sp_in_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_FULL)
    else $error("stack pointer beyond stack depth");

  a_done_only_busy: assert property (@(posedge clk) disable iff (rst)
    u_done |-> (state == S_BUSY))
    else $error("arithmetic unit finished outside busy state");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == S_OUT))
    else $error("result presented outside output state");

endmodule

/* src/rpnsc_stack_ram.sv */
module rpnsc_stack_ram
  import rpnsc_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);

  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/rpnsc_iter_unit.sv */
module rpnsc_iter_unit
  import rpnsc_pkg::*;
#(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  unit_req_t   req,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] result
);

  localparam int CW = $clog2(64 + FRACTION_BITS + 1);
  localparam logic [CW-1:0] WORD_STEPS = CW'(64);
  localparam logic [CW-1:0] DIV_STEPS  = CW'(64 + FRACTION_BITS);

  logic          busy;
  logic [1:0]    op;
  logic [CW-1:0] cnt;
  logic [63:0]   x;
  logic [127:0]  acc;
  logic [63:0]   rem;
  logic [63:0]   q;
  logic          ovf;
  logic          neg;
  logic          a_neg;

  logic [63:0]  xa, yb;
  logic [64:0]  rs, add_a, add_b;
  logic [65:0]  sum;
  logic         ge;
  logic [64:0]  hi_new;
  logic [127:0] shifted;
  logic [63:0]  mod_t;

  assign xa = magnitude(a);
  assign yb = magnitude(b);

  // One adder serves both: hi + x for multiply, rs - x for division.
  assign rs     = {rem, acc[127]};
  assign add_a  = (op == UOP_MUL) ? {1'b0, acc[127:64]} : rs;
  assign add_b  = (op == UOP_MUL) ? {1'b0, x} : ~{1'b0, x};
  assign sum    = {1'b0, add_a} + {1'b0, add_b} + {65'd0, (op != UOP_MUL)};
  assign ge     = sum[65];
  assign hi_new = acc[0] ? sum[64:0] : {1'b0, acc[127:64]};

  assign shifted = acc >> FRACTION_BITS;
  assign mod_t   = rem << FRACTION_BITS;

  always_comb begin
    unique case (op)
      UOP_MUL: result = sat_sign(shifted[63:0], neg, |shifted[127:64]);
      UOP_DIV: result = sat_sign(q, neg, ovf);
      default: result = a_neg ? (~mod_t + 64'd1) : mod_t;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op   <= UOP_MUL;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        op    <= req.op;
        neg   <= a[63] ^ b[63];
        a_neg <= a[63];
        rem   <= '0;
        q     <= '0;
        ovf   <= 1'b0;
        unique case (req.op)
          UOP_MUL: begin
            x   <= xa;
            acc <= {64'd0, yb};
            cnt <= WORD_STEPS;
          end
          UOP_DIV: begin
            x   <= yb;
            acc <= {xa, 64'd0};
            cnt <= DIV_STEPS;
          end
          default: begin
            x   <= yb >> FRACTION_BITS;
            acc <= {xa >> FRACTION_BITS, 64'd0};
            cnt <= WORD_STEPS;
          end
        endcase
      end else if (busy) begin
        if (op == UOP_MUL) begin
          acc <= {hi_new, acc[63:1]};
        end else begin
          rem <= ge ? sum[63:0] : rs[63:0];
          acc <= {acc[126:0], 1'b0};
          q   <= {q[62:0], ge};
          // A quotient bit above the word means the result cannot fit.
          if (ge && cnt > WORD_STEPS) begin
            ovf <= 1'b1;
          end
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
